FILE: design/motor_speed_pid_with_brake_core_defines.svh
// Assertion macros for the checker file of the speed controller.
`ifndef MOTOR_SPEED_PID_WITH_BRAKE_CORE_DEFINES_SVH
`define MOTOR_SPEED_PID_WITH_BRAKE_CORE_DEFINES_SVH

// Checked only out of reset.
`define MSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define MSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: design/msp_pkg.sv
// Types, constants and codes of the motor speed PD controller with brake.
`timescale 1ns / 1ps

package msp_pkg;

    localparam int SPEED_W    = 11;
    localparam int ERR_W      = 12;
    localparam int DERR_W     = 13;
    localparam int DUTY_W     = 14;
    localparam int GAIN_W     = 8;
    localparam int CNT_W      = 8;
    localparam int THR_W      = 5;
    localparam int SUM_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_D       = 3'd1,
        REG_DUTY_LIMIT   = 3'd2,
        REG_BOOST_DUTY   = 3'd3,
        REG_BOOST_MARGIN = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_BRAKE = 2'd0,
        MODE_BOOST = 2'd1,
        MODE_PID   = 2'd2
    } drive_mode_t;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST       = 8'd40;
    localparam logic [GAIN_W-1:0] GAIN_D_RST       = 8'd25;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST   = 14'd7000;
    localparam logic [DUTY_W-1:0] BOOST_DUTY_RST   = 14'd5500;
    localparam logic [GAIN_W-1:0] BOOST_MARGIN_RST = 8'd6;

    // Reverse-brake duties
    localparam logic [DUTY_W-1:0] BRAKE_RING     = 14'd4500;
    localparam logic [DUTY_W-1:0] BRAKE_OBSTACLE = 14'd1000;
    localparam logic [DUTY_W-1:0] BRAKE_STOP     = 14'd2000;
    localparam logic [DUTY_W-1:0] BRAKE_RAMP     = 14'd1000;
    localparam logic [DUTY_W-1:0] BRAKE_NONE     = 14'd0;

    // Error thresholds below which the motor reverses
    localparam logic signed [THR_W-1:0] THR_RING     = 5'sd0;
    localparam logic signed [THR_W-1:0] THR_OBSTACLE = -5'sd6;
    localparam logic signed [THR_W-1:0] THR_STOP     = -5'sd4;
    localparam logic signed [THR_W-1:0] THR_RAMP     = -5'sd5;
    localparam logic signed [THR_W-1:0] THR_ENTRY    = 5'sd0;
    localparam logic signed [THR_W-1:0] THR_DEFAULT  = -5'sd10;

    localparam logic [CNT_W-1:0]          STOP_DELAY_MIN = 8'd30;
    localparam logic [CNT_W-1:0]          STRAIGHT_MIN   = 8'd20;
    localparam logic signed [SPEED_W-1:0] STOP_SPEED_MIN = 11'sd6;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0] duty_limit;
        logic [DUTY_W-1:0] boost_duty;
        logic [GAIN_W-1:0] boost_margin;
    } cfg_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic signed [SPEED_W-1:0] measured_speed;
        logic                      ring_turn;
        logic                      obstacle;
        logic [CNT_W-1:0]          stop_delay_count;
        logic                      ramp;
        logic [CNT_W-1:0]          straight_count;
        logic                      straight_entry;
        logic                      steady_mode;
        logic                      start_line_seen;
    } item_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] prev_error;
        logic [DUTY_W-1:0]       prev_duty;
    } state_t;

    typedef struct packed {
        logic              reverse;
        logic [DUTY_W-1:0] duty;
        drive_mode_t       drive_mode;
        logic              clear_straight_entry;
    } res_t;

endpackage

FILE: design/motor_speed_pid_with_brake_core.sv
// Path: an accepted input is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the result side stalls; the PD state is updated as an
//   item passes into the result register, so the next item in the input register already sees it.
// The duty loop (8-bit gains by the 12-bit error and 13-bit error change, add/clamp) sets the path.
// Reset (aresetn, synchronous, active low): both stages empty, PD state zero,
//   registers to their defaults; configuration writes are taken every cycle.
`timescale 1ns / 1ps

module motor_speed_pid_with_brake_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [msp_pkg::SPEED_W-1:0]    s_target_speed,
    input  logic signed [msp_pkg::SPEED_W-1:0]    s_measured_speed,
    input  logic                                  s_ring_turn,
    input  logic                                  s_obstacle,
    input  logic [msp_pkg::CNT_W-1:0]             s_stop_delay_count,
    input  logic                                  s_ramp,
    input  logic [msp_pkg::CNT_W-1:0]             s_straight_count,
    input  logic                                  s_straight_entry,
    input  logic                                  s_steady_mode,
    input  logic                                  s_start_line_seen,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_reverse,
    output logic [msp_pkg::DUTY_W-1:0]            m_duty,
    output logic [1:0]                            m_drive_mode,
    output logic                                  m_clear_straight_entry,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    msp_pkg::cfg_t   cfg;
    msp_pkg::item_t  item_reg, item_next;
    msp_pkg::state_t state_reg, state_next;
    msp_pkg::res_t   res_reg, res_comb;
    logic            in_valid_reg, in_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            s_xfer;
    logic            advance;

    // Config writes never stall.
    assign cfg_ready = 1'b1;

    msp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msp_calc u_calc (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .res        (res_comb),
        .state_next (state_next)
    );

    // An item moves on when the result register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        item_next.target_speed     = s_target_speed;
        item_next.measured_speed   = s_measured_speed;
        item_next.ring_turn        = s_ring_turn;
        item_next.obstacle         = s_obstacle;
        item_next.stop_delay_count = s_stop_delay_count;
        item_next.ramp             = s_ramp;
        item_next.straight_count   = s_straight_count;
        item_next.straight_entry   = s_straight_entry;
        item_next.steady_mode      = s_steady_mode;
        item_next.start_line_seen  = s_start_line_seen;

        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and PD state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= item_next;
        end
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_reverse              = res_reg.reverse;
    assign m_duty                 = res_reg.duty;
    assign m_drive_mode           = res_reg.drive_mode;
    assign m_clear_straight_entry = res_reg.clear_straight_entry;

endmodule

FILE: design/msp_cfg.sv
// Configuration register file of the speed controller.
`timescale 1ns / 1ps

module msp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [msp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output msp_pkg::cfg_t                    cfg
);

    msp_pkg::cfg_t cfg_reg;
    msp_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                msp_pkg::REG_GAIN_P:
                    cfg_next.gain_p = cfg_wdata[msp_pkg::GAIN_W-1:0];
                msp_pkg::REG_GAIN_D:
                    cfg_next.gain_d = cfg_wdata[msp_pkg::GAIN_W-1:0];
                msp_pkg::REG_DUTY_LIMIT:
                    cfg_next.duty_limit = cfg_wdata[msp_pkg::DUTY_W-1:0];
                msp_pkg::REG_BOOST_DUTY:
                    cfg_next.boost_duty = cfg_wdata[msp_pkg::DUTY_W-1:0];
                msp_pkg::REG_BOOST_MARGIN:
                    cfg_next.boost_margin = cfg_wdata[msp_pkg::GAIN_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p       <= msp_pkg::GAIN_P_RST;
            cfg_reg.gain_d       <= msp_pkg::GAIN_D_RST;
            cfg_reg.duty_limit   <= msp_pkg::DUTY_LIMIT_RST;
            cfg_reg.boost_duty   <= msp_pkg::BOOST_DUTY_RST;
            cfg_reg.boost_margin <= msp_pkg::BOOST_MARGIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/msp_calc.sv
// Single-pass PD duty, brake selection and drive decision for one tick.
`timescale 1ns / 1ps

module msp_calc (
    input  msp_pkg::item_t  item,
    input  msp_pkg::cfg_t   cfg,
    input  msp_pkg::state_t state,
    output msp_pkg::res_t   res,
    output msp_pkg::state_t state_next
);

    localparam int SW = msp_pkg::SUM_W;

    logic [msp_pkg::DUTY_W-1:0]         brake_duty;
    logic signed [msp_pkg::THR_W-1:0]   thresh;
    logic                               clr;
    logic signed [msp_pkg::ERR_W-1:0]   err;
    logic signed [msp_pkg::DERR_W-1:0]  derr;
    logic signed [SW-1:0]               gp_s, gd_s, err_s, derr_s, pd_s, lim_s;
    logic signed [SW-1:0]               p_term, d_term, u;
    logic [msp_pkg::DUTY_W-1:0]         u_cl;
    logic signed [msp_pkg::ERR_W-1:0]   thresh_e, margin_e;

    // Road-flag priority chain
    always_comb begin
        clr = 1'b0;
        if (item.ring_turn) begin
            brake_duty = msp_pkg::BRAKE_RING;
            thresh     = msp_pkg::THR_RING;
        end else if (item.obstacle) begin
            brake_duty = msp_pkg::BRAKE_OBSTACLE;
            thresh     = msp_pkg::THR_OBSTACLE;
        end else if (item.stop_delay_count > msp_pkg::STOP_DELAY_MIN &&
                     item.measured_speed > msp_pkg::STOP_SPEED_MIN) begin
            brake_duty = msp_pkg::BRAKE_STOP;
            thresh     = msp_pkg::THR_STOP;
        end else if (item.ramp) begin
            brake_duty = msp_pkg::BRAKE_RAMP;
            thresh     = msp_pkg::THR_RAMP;
        end else if (item.straight_count > msp_pkg::STRAIGHT_MIN) begin
            clr        = 1'b1;
            brake_duty = msp_pkg::BRAKE_NONE;
            thresh     = msp_pkg::THR_DEFAULT;
        end else if (item.straight_entry) begin
            brake_duty = msp_pkg::BRAKE_NONE;
            thresh     = msp_pkg::THR_ENTRY;
        end else begin
            brake_duty = msp_pkg::BRAKE_NONE;
            thresh     = msp_pkg::THR_DEFAULT;
        end
        // steady rule overrides the chain but leaves the clear flag
        if (item.steady_mode && !item.start_line_seen) begin
            brake_duty = msp_pkg::BRAKE_NONE;
            thresh     = msp_pkg::THR_DEFAULT;
        end
    end

    // Incremental PD sum
    always_comb begin
        err    = {item.target_speed[msp_pkg::SPEED_W-1], item.target_speed}
               - {item.measured_speed[msp_pkg::SPEED_W-1], item.measured_speed};
        derr   = {err[msp_pkg::ERR_W-1], err}
               - {state.prev_error[msp_pkg::ERR_W-1], state.prev_error};
        gp_s   = {{(SW-msp_pkg::GAIN_W){1'b0}}, cfg.gain_p};
        gd_s   = {{(SW-msp_pkg::GAIN_W){1'b0}}, cfg.gain_d};
        err_s  = {{(SW-msp_pkg::ERR_W){err[msp_pkg::ERR_W-1]}}, err};
        derr_s = {{(SW-msp_pkg::DERR_W){derr[msp_pkg::DERR_W-1]}}, derr};
        pd_s   = {{(SW-msp_pkg::DUTY_W){1'b0}}, state.prev_duty};
        lim_s  = {{(SW-msp_pkg::DUTY_W){1'b0}}, cfg.duty_limit};
        p_term = gp_s * err_s;
        d_term = gd_s * derr_s;
        u      = pd_s + p_term + d_term;
        if (u > lim_s) begin
            u_cl = cfg.duty_limit;
        end else if (u < 0) begin
            u_cl = '0;
        end else begin
            u_cl = u[msp_pkg::DUTY_W-1:0];
        end
    end

    // Drive decision
    always_comb begin
        thresh_e = {{(msp_pkg::ERR_W-msp_pkg::THR_W){thresh[msp_pkg::THR_W-1]}}, thresh};
        margin_e = {{(msp_pkg::ERR_W-msp_pkg::GAIN_W){1'b0}}, cfg.boost_margin};
        res.clear_straight_entry = clr;
        if (err < thresh_e) begin
            res.reverse    = 1'b1;
            res.duty       = brake_duty;
            res.drive_mode = msp_pkg::MODE_BRAKE;
        end else if (err > margin_e) begin
            res.reverse    = 1'b0;
            res.duty       = cfg.boost_duty;
            res.drive_mode = msp_pkg::MODE_BOOST;
        end else begin
            res.reverse    = 1'b0;
            res.duty       = u_cl;
            res.drive_mode = msp_pkg::MODE_PID;
        end
        state_next.prev_error = err;
        state_next.prev_duty  = u_cl;
    end

endmodule

FILE: design/msp_checker.sv
// Port-level checks of the speed controller, bound to the top level.
`timescale 1ns / 1ps
`include "motor_speed_pid_with_brake_core_defines.svh"

module msp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_reverse,
    input logic [msp_pkg::DUTY_W-1:0]          m_duty,
    input logic [1:0]                          m_drive_mode,
    input logic                                m_clear_straight_entry
);

    // stalled result holds
    `MSP_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_duty) && $stable(m_drive_mode) && $stable(m_reverse) && $stable(m_clear_straight_entry), "stalled result changed")

    // reverse is shown exactly for the brake mode
    `MSP_ASSERT(a_reverse_mode, m_valid |-> (m_reverse == (m_drive_mode == msp_pkg::MODE_BRAKE)), "reverse flag disagrees with drive mode")

    // brake duty comes only from the fixed brake table
    `MSP_ASSERT(a_brake_duty, m_valid && m_drive_mode == msp_pkg::MODE_BRAKE |-> (m_duty == msp_pkg::BRAKE_NONE || m_duty == msp_pkg::BRAKE_OBSTACLE || m_duty == msp_pkg::BRAKE_STOP || m_duty == msp_pkg::BRAKE_RING), "brake duty outside table")

    // reset empties the result stage
    `MSP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind motor_speed_pid_with_brake_core msp_checker u_msp_checker (.*);

FILE: bench/motor_speed_pid_with_brake_core_tb.sv
// Self-checking testbench for the motor speed PD controller with reverse brake and boost.
`timescale 1ns / 1ps

module motor_speed_pid_with_brake_core_tb;

    // Run shape: one table of directed ticks, then random phases, each with its own
    // register settings; the last phase runs with no idling on either side.
    localparam int PHASES       = 10;
    localparam int PHASE_TICKS  = 170;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 8;
    localparam int CFG_DATA_MAX = (1 << msp_pkg::CFG_DATA_W) - 1;
    localparam int CFG_IDX_MAX  = (1 << msp_pkg::CFG_IDX_W) - 1;
    localparam int DUTY_MAX     = 10000;

    // Brake chain, written out independently of the design package
    localparam int BRAKE_DUTY_RING  = 4500;
    localparam int BRAKE_DUTY_OBST  = 1000;
    localparam int BRAKE_DUTY_STOP  = 2000;
    localparam int BRAKE_DUTY_RAMP  = 1000;
    localparam int LIMIT_RING       = 0;
    localparam int LIMIT_OBST       = -6;
    localparam int LIMIT_STOP       = -4;
    localparam int LIMIT_RAMP       = -5;
    localparam int LIMIT_ENTRY      = 0;
    localparam int LIMIT_PLAIN      = -10;
    localparam int STOP_TICKS_MIN   = 30;
    localparam int STOP_SPEED_FLOOR = 6;
    localparam int STRAIGHT_RUN_MIN = 20;

    // Road flag bits used to build ticks
    localparam logic [5:0] FL_RING   = 6'b000001;
    localparam logic [5:0] FL_OBST   = 6'b000010;
    localparam logic [5:0] FL_RAMP   = 6'b000100;
    localparam logic [5:0] FL_ENTRY  = 6'b001000;
    localparam logic [5:0] FL_STEADY = 6'b010000;
    localparam logic [5:0] FL_START  = 6'b100000;

    typedef struct {
        msp_pkg::item_t stim;
        logic           fixed;
        msp_pkg::res_t  want;
    } dir_row_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [msp_pkg::SPEED_W-1:0]   s_target_speed;
    logic signed [msp_pkg::SPEED_W-1:0]   s_measured_speed;
    logic                                 s_ring_turn;
    logic                                 s_obstacle;
    logic [msp_pkg::CNT_W-1:0]            s_stop_delay_count;
    logic                                 s_ramp;
    logic [msp_pkg::CNT_W-1:0]            s_straight_count;
    logic                                 s_straight_entry;
    logic                                 s_steady_mode;
    logic                                 s_start_line_seen;
    logic                                 m_valid;
    logic                                 m_ready;
    logic                                 m_reverse;
    logic [msp_pkg::DUTY_W-1:0]           m_duty;
    logic [1:0]                           m_drive_mode;
    logic                                 m_clear_straight_entry;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [msp_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [msp_pkg::CFG_DATA_W-1:0]       cfg_wdata;

    // Shadow of the control registers and of the PD loop state
    int cfg_gain_p       = 40;
    int cfg_gain_d       = 25;
    int cfg_duty_limit   = 7000;
    int cfg_boost_duty   = 5500;
    int cfg_boost_margin = 6;
    int pd_last_error    = 0;
    int pd_last_duty     = 0;

    msp_pkg::res_t pending_drive[$];      // drive commands still owed by the block
    int   errors      = 0;
    int   cycle_count = 0;
    int   idle_pct    = 0;       // chance of a gap before an input transfer
    int   stall_pct   = 0;       // chance of a stall burst on the result side
    logic calm        = 1'b0;    // no idling at all in the closing phase

    motor_speed_pid_with_brake_core i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_target_speed         (s_target_speed),
        .s_measured_speed       (s_measured_speed),
        .s_ring_turn            (s_ring_turn),
        .s_obstacle             (s_obstacle),
        .s_stop_delay_count     (s_stop_delay_count),
        .s_ramp                 (s_ramp),
        .s_straight_count       (s_straight_count),
        .s_straight_entry       (s_straight_entry),
        .s_steady_mode          (s_steady_mode),
        .s_start_line_seen      (s_start_line_seen),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_reverse              (m_reverse),
        .m_duty                 (m_duty),
        .m_drive_mode           (m_drive_mode),
        .m_clear_straight_entry (m_clear_straight_entry),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // One control tick of the controller: brake chain, PD update, output choice.
    // Updates the shadow loop state, as the block does on every tick.
    function automatic msp_pkg::res_t predict_drive(msp_pkg::item_t it);
        int            tgt;
        int            meas;
        int            err;
        int            u;
        int            brake;
        int            limit;
        logic          clr;
        msp_pkg::res_t r;
        tgt  = it.target_speed;
        meas = it.measured_speed;
        clr  = 1'b0;
        if (it.ring_turn) begin
            brake = BRAKE_DUTY_RING;
            limit = LIMIT_RING;
        end else if (it.obstacle) begin
            brake = BRAKE_DUTY_OBST;
            limit = LIMIT_OBST;
        end else if (int'(it.stop_delay_count) > STOP_TICKS_MIN
                     && meas > STOP_SPEED_FLOOR) begin
            brake = BRAKE_DUTY_STOP;
            limit = LIMIT_STOP;
        end else if (it.ramp) begin
            brake = BRAKE_DUTY_RAMP;
            limit = LIMIT_RAMP;
        end else if (int'(it.straight_count) > STRAIGHT_RUN_MIN) begin
            clr   = 1'b1;
            brake = 0;
            limit = LIMIT_PLAIN;
        end else if (it.straight_entry) begin
            brake = 0;
            limit = LIMIT_ENTRY;
        end else begin
            brake = 0;
            limit = LIMIT_PLAIN;
        end
        // steady rule overrides the chain but leaves the clear flag alone
        if (it.steady_mode && !it.start_line_seen) begin
            brake = 0;
            limit = LIMIT_PLAIN;
        end

        err = tgt - meas;
        u   = pd_last_duty + cfg_gain_p * err + cfg_gain_d * (err - pd_last_error);
        if (u > cfg_duty_limit) u = cfg_duty_limit;
        if (u < 0) u = 0;
        pd_last_duty  = u;
        pd_last_error = err;

        r.clear_straight_entry = clr;
        if (err < limit) begin
            r.reverse    = 1'b1;
            r.duty       = msp_pkg::DUTY_W'(brake);
            r.drive_mode = msp_pkg::MODE_BRAKE;
        end else if (err > cfg_boost_margin) begin
            r.reverse    = 1'b0;
            r.duty       = msp_pkg::DUTY_W'(cfg_boost_duty);
            r.drive_mode = msp_pkg::MODE_BOOST;
        end else begin
            r.reverse    = 1'b0;
            r.duty       = msp_pkg::DUTY_W'(u);
            r.drive_mode = msp_pkg::MODE_PID;
        end
        return r;
    endfunction

    function automatic msp_pkg::item_t tick_in(int tgt, int meas, int stop_cnt, int str_cnt,
                                               logic [5:0] flags);
        msp_pkg::item_t it;
        it.target_speed     = msp_pkg::SPEED_W'(tgt);
        it.measured_speed   = msp_pkg::SPEED_W'(meas);
        it.ring_turn        = |(flags & FL_RING);
        it.obstacle         = |(flags & FL_OBST);
        it.stop_delay_count = msp_pkg::CNT_W'(stop_cnt);
        it.ramp             = |(flags & FL_RAMP);
        it.straight_count   = msp_pkg::CNT_W'(str_cnt);
        it.straight_entry   = |(flags & FL_ENTRY);
        it.steady_mode      = |(flags & FL_STEADY);
        it.start_line_seen  = |(flags & FL_START);
        return it;
    endfunction

    // Directed row with its result typed in
    function automatic dir_row_t pinned(msp_pkg::item_t it, logic rev, int duty,
                                        msp_pkg::drive_mode_t mode, logic clr);
        dir_row_t d;
        d.stim                      = it;
        d.fixed                     = 1'b1;
        d.want.reverse              = rev;
        d.want.duty                 = msp_pkg::DUTY_W'(duty);
        d.want.drive_mode           = mode;
        d.want.clear_straight_entry = clr;
        return d;
    endfunction

    // Directed row left to the predictor
    function automatic dir_row_t free_row(msp_pkg::item_t it);
        dir_row_t d;
        d.stim  = it;
        d.fixed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // with valid still high so back-to-back ticks need no gap.
    task automatic send_tick(input msp_pkg::item_t it, input logic fixed,
                             input msp_pkg::res_t want);
        msp_pkg::res_t r;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_target_speed     = it.target_speed;
        s_measured_speed   = it.measured_speed;
        s_ring_turn        = it.ring_turn;
        s_obstacle         = it.obstacle;
        s_stop_delay_count = it.stop_delay_count;
        s_ramp             = it.ramp;
        s_straight_count   = it.straight_count;
        s_straight_entry   = it.straight_entry;
        s_steady_mode      = it.steady_mode;
        s_start_line_seen  = it.start_line_seen;
        s_valid            = 1'b1;
        do @(posedge aclk); while (!s_ready);
        // predictor runs for every tick so the loop state stays in step
        r = predict_drive(it);
        pending_drive.push_back(fixed ? want : r);
        @(negedge aclk);
    endtask

    // Register write; the shadow copy follows only once the transfer happens.
    task automatic write_reg(input int idx, input int data);
        cfg_valid = 1'b1;
        cfg_index = msp_pkg::CFG_IDX_W'(idx);
        cfg_wdata = msp_pkg::CFG_DATA_W'(data);
        do @(posedge aclk); while (!cfg_ready);
        case (cfg_index)
            msp_pkg::REG_GAIN_P:       cfg_gain_p       = int'(cfg_wdata[msp_pkg::GAIN_W-1:0]);
            msp_pkg::REG_GAIN_D:       cfg_gain_d       = int'(cfg_wdata[msp_pkg::GAIN_W-1:0]);
            msp_pkg::REG_DUTY_LIMIT:   cfg_duty_limit   = int'(cfg_wdata[msp_pkg::DUTY_W-1:0]);
            msp_pkg::REG_BOOST_DUTY:   cfg_boost_duty   = int'(cfg_wdata[msp_pkg::DUTY_W-1:0]);
            msp_pkg::REG_BOOST_MARGIN: cfg_boost_margin = int'(cfg_wdata[msp_pkg::GAIN_W-1:0]);
            default: ;   // spare indexes are ignored by the block
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random stall bursts, with runs of steady ready between them
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
        end
    end

    // Result checker: every transfer against the oldest owed command
    always @(posedge aclk) begin
        msp_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drive.size() == 0) begin
                $display("%0t: unexpected result, duty %0d mode %0d", $time, m_duty,
                         m_drive_mode);
                errors++;
            end else begin
                want = pending_drive.pop_front();
                if (m_reverse !== want.reverse) begin
                    $display("%0t: reverse mismatch, expected %0d, got %0d", $time,
                             want.reverse, m_reverse);
                    errors++;
                end
                if (m_duty !== want.duty) begin
                    $display("%0t: duty mismatch, expected %0d, got %0d", $time,
                             want.duty, m_duty);
                    errors++;
                end
                if (m_drive_mode !== want.drive_mode) begin
                    $display("%0t: drive mode mismatch, expected %0d, got %0d", $time,
                             want.drive_mode, m_drive_mode);
                    errors++;
                end
                if (m_clear_straight_entry !== want.clear_straight_entry) begin
                    $display("%0t: clear flag mismatch, expected %0d, got %0d", $time,
                             want.clear_straight_entry, m_clear_straight_entry);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d results still owed", $time, pending_drive.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        dir_row_t       dir_table[$];
        msp_pkg::item_t it;
        msp_pkg::res_t  none;
        int             meas;
        int             tgt;
        int             delta;
        int             stop_cnt;
        int             str_cnt;
        int             flag_pct;
        logic [5:0]     flags;

        aclk               = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_target_speed     = '0;
        s_measured_speed   = '0;
        s_ring_turn        = 1'b0;
        s_obstacle         = 1'b0;
        s_stop_delay_count = '0;
        s_ramp             = 1'b0;
        s_straight_count   = '0;
        s_straight_entry   = 1'b0;
        s_steady_mode      = 1'b0;
        s_start_line_seen  = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        none               = '0;

        // Directed ticks, run under the reset register values.
        // Quiet tick straight out of reset: zero error, zero duty.
        dir_table.push_back(pinned(tick_in(0, 0, 0, 0, 0), 1'b0, 0, msp_pkg::MODE_PID,
                                   1'b0));
        // Largest positive error: boost, PD duty saturates at the limit
        dir_table.push_back(pinned(tick_in(1023, -1024, 0, 0, 0), 1'b0, 5500,
                                   msp_pkg::MODE_BOOST, 1'b0));
        // Largest negative error inside a ring, PD duty floors at zero
        dir_table.push_back(pinned(tick_in(-1024, 1023, 0, 0, FL_RING), 1'b1, 4500,
                                   msp_pkg::MODE_BRAKE, 1'b0));
        // Obstacle, either side of its threshold
        dir_table.push_back(pinned(tick_in(0, 7, 0, 0, FL_OBST), 1'b1, 1000,
                                   msp_pkg::MODE_BRAKE, 1'b0));
        dir_table.push_back(free_row(tick_in(0, 6, 0, 0, FL_OBST)));
        // Stop-line rule: count and speed both just past, then each just short
        dir_table.push_back(pinned(tick_in(2, 7, 31, 0, 0), 1'b1, 2000,
                                   msp_pkg::MODE_BRAKE, 1'b0));
        dir_table.push_back(free_row(tick_in(2, 7, 30, 0, 0)));
        dir_table.push_back(free_row(tick_in(1, 6, 31, 0, 0)));
        dir_table.push_back(pinned(tick_in(1017, 1023, 255, 0, 0), 1'b1, 2000,
                                   msp_pkg::MODE_BRAKE, 1'b0));
        // Obstacle outranks the stop rule
        dir_table.push_back(free_row(tick_in(2, 7, 31, 0, FL_OBST)));
        // Ramp, either side of its threshold
        dir_table.push_back(pinned(tick_in(0, 6, 0, 0, FL_RAMP), 1'b1, 1000,
                                   msp_pkg::MODE_BRAKE, 1'b0));
        dir_table.push_back(free_row(tick_in(0, 5, 0, 0, FL_RAMP)));
        // Long straight: clear request, reverse with zero duty
        dir_table.push_back(pinned(tick_in(0, 11, 0, 21, 0), 1'b1, 0,
                                   msp_pkg::MODE_BRAKE, 1'b1));
        // Curve entry with straight count at its bound
        dir_table.push_back(pinned(tick_in(0, 1, 0, 20, FL_ENTRY), 1'b1, 0,
                                   msp_pkg::MODE_BRAKE, 1'b0));
        dir_table.push_back(free_row(tick_in(0, 0, 0, 255, FL_ENTRY)));
        // Steady rule overrides the ring brake, keeps the clear request
        dir_table.push_back(free_row(tick_in(0, 5, 0, 0, FL_RING | FL_STEADY)));
        dir_table.push_back(pinned(tick_in(0, 20, 0, 200, FL_STEADY), 1'b1, 0,
                                   msp_pkg::MODE_BRAKE, 1'b1));
        // Start line seen disables the steady rule
        dir_table.push_back(pinned(tick_in(0, 1, 0, 0, FL_RING | FL_STEADY | FL_START),
                                   1'b1, 4500, msp_pkg::MODE_BRAKE, 1'b0));
        dir_table.push_back(free_row(tick_in(5, 5, 0, 0, FL_RING)));
        // Boost margin edge, plain threshold edge
        dir_table.push_back(free_row(tick_in(6, 0, 0, 0, 0)));
        dir_table.push_back(pinned(tick_in(7, 0, 0, 0, 0), 1'b0, 5500,
                                   msp_pkg::MODE_BOOST, 1'b0));
        dir_table.push_back(free_row(tick_in(0, 10, 0, 0, 0)));
        // Every flag and count bit set at once
        dir_table.push_back(free_row(tick_in(-1, -1, 255, 255, 6'b111111)));

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_table[i])
            send_tick(dir_table[i].stim, dir_table[i].fixed, dir_table[i].want);
        s_valid = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            // registers only change with the pipe empty
            while (pending_drive.size() != 0) @(negedge aclk);
            case (ph)
                0: begin
                    // all ones: gains and margin at 255, limits past the legal range
                    write_reg(msp_pkg::REG_GAIN_P, CFG_DATA_MAX);
                    write_reg(msp_pkg::REG_GAIN_D, CFG_DATA_MAX);
                    write_reg(msp_pkg::REG_DUTY_LIMIT, CFG_DATA_MAX);
                    write_reg(msp_pkg::REG_BOOST_DUTY, CFG_DATA_MAX);
                    write_reg(msp_pkg::REG_BOOST_MARGIN, CFG_DATA_MAX);
                end
                1: begin
                    write_reg(msp_pkg::REG_GAIN_P, 0);
                    write_reg(msp_pkg::REG_GAIN_D, 0);
                    write_reg(msp_pkg::REG_DUTY_LIMIT, 0);
                    write_reg(msp_pkg::REG_BOOST_DUTY, 0);
                    write_reg(msp_pkg::REG_BOOST_MARGIN, 0);
                end
                default: begin
                    write_reg(msp_pkg::REG_GAIN_P, $urandom_range(0, CFG_DATA_MAX));
                    write_reg(msp_pkg::REG_GAIN_D, $urandom_range(0, CFG_DATA_MAX));
                    write_reg(msp_pkg::REG_DUTY_LIMIT, ($urandom_range(0, 4) == 0)
                              ? $urandom_range(0, CFG_DATA_MAX) : $urandom_range(0, DUTY_MAX));
                    write_reg(msp_pkg::REG_BOOST_DUTY, ($urandom_range(0, 4) == 0)
                              ? $urandom_range(0, CFG_DATA_MAX) : $urandom_range(0, DUTY_MAX));
                    // small margins keep boost within reach of small errors
                    write_reg(msp_pkg::REG_BOOST_MARGIN, ($urandom_range(0, 9) < 7)
                              ? $urandom_range(0, 16) : $urandom_range(0, CFG_DATA_MAX));
                end
            endcase
            write_reg($urandom_range(msp_pkg::REG_BOOST_MARGIN + 1, CFG_IDX_MAX),
                      $urandom_range(0, CFG_DATA_MAX));

            calm = (ph == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 35;
            endcase
            flag_pct = $urandom_range(10, 50);

            repeat (PHASE_TICKS) begin
                // a quarter of the speeds near zero so the stop rule sees both sides of its floor
                meas = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) - 20
                                                   : $urandom_range(0, 2047) - 1024;
                if ($urandom_range(0, 1)) begin
                    // error close to the thresholds and the boost margin
                    delta = $urandom_range(0, 32);
                    delta = delta - 16;
                    tgt   = meas + delta;
                    if (tgt > 1023) tgt = 1023;
                    if (tgt < -1024) tgt = -1024;
                end else begin
                    tgt = $urandom_range(0, 2047) - 1024;
                end
                stop_cnt = $urandom_range(0, 1) ? $urandom_range(24, 36)
                                                : $urandom_range(0, 255);
                str_cnt  = $urandom_range(0, 1) ? $urandom_range(14, 26)
                                                : $urandom_range(0, 255);
                for (int b = 0; b < 6; b++)
                    flags[b] = ($urandom_range(0, 99) < flag_pct);
                it = tick_in(tgt, meas, stop_cnt, str_cnt, flags);
                send_tick(it, 1'b0, none);
            end
            s_valid = 1'b0;
        end

        while (pending_drive.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
